// ===== sv/assert_macros.svh =====
// Assertion macros shared by the MD5 digest RTL.
// Takes nothing from other files; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MD5_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("md5 same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define MD5_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("md5 next-cycle check failed");

`endif

// ===== sv/md5_pkg.sv =====
`timescale 1ns / 1ps
// Package for the MD5 digest block: payload types, controller commands and status,
// round constants and round helper functions. Depends on nothing.
package md5_pkg;

   localparam int BLOCK_BYTES   = 64;
   localparam int BLOCK_WORDS   = BLOCK_BYTES / 4;
   localparam int POS_W         = $clog2(BLOCK_BYTES);
   localparam int WADDR_W       = $clog2(BLOCK_WORDS);
   localparam int ROUNDS        = 64;
   localparam int ROUND_W       = $clog2(ROUNDS);
   localparam int BIT_COUNT_W   = 64;
   localparam int BYTE_COUNT_W  = BIT_COUNT_W - 3;
   localparam int WORD_IDX_W    = 2;

   // Function codes of an input transfer.
   localparam logic FUNC_ABSORB = 1'b0;
   localparam logic FUNC_FINISH = 1'b1;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   // Byte position of the final message or padding byte of a block, and the
   // position after which the length field begins.
   localparam logic [POS_W-1:0] LAST_POS     = POS_W'(BLOCK_BYTES - 1);
   localparam logic [POS_W-1:0] LAST_PAD_POS = POS_W'(BLOCK_BYTES - 9);

   localparam logic [WADDR_W-1:0] LEN_LO_WORD = WADDR_W'(BLOCK_WORDS - 2);
   localparam logic [WADDR_W-1:0] LEN_HI_WORD = WADDR_W'(BLOCK_WORDS - 1);

   localparam logic [WORD_IDX_W-1:0] LAST_WORD = '1;
   localparam logic [ROUND_W-1:0]    LAST_ROUND = '1;

   localparam logic [31:0] CHAIN_INIT [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam logic [31:0] ROUND_CONST [ROUNDS] = '{
      32'd3614090360, 32'd3905402710, 32'd606105819,  32'd3250441966,
      32'd4118548399, 32'd1200080426, 32'd2821735955, 32'd4249261313,
      32'd1770035416, 32'd2336552879, 32'd4294925233, 32'd2304563134,
      32'd1804603682, 32'd4254626195, 32'd2792965006, 32'd1236535329,
      32'd4129170786, 32'd3225465664, 32'd643717713,  32'd3921069994,
      32'd3593408605, 32'd38016083,   32'd3634488961, 32'd3889429448,
      32'd568446438,  32'd3275163606, 32'd4107603335, 32'd1163531501,
      32'd2850285829, 32'd4243563512, 32'd1735328473, 32'd2368359562,
      32'd4294588738, 32'd2272392833, 32'd1839030562, 32'd4259657740,
      32'd2763975236, 32'd1272893353, 32'd4139469664, 32'd3200236656,
      32'd681279174,  32'd3936430074, 32'd3572445317, 32'd76029189,
      32'd3654602809, 32'd3873151461, 32'd530742520,  32'd3299628645,
      32'd4096336452, 32'd1126891415, 32'd2878612391, 32'd4237533241,
      32'd1700485571, 32'd2399980690, 32'd4293915773, 32'd2240044497,
      32'd1873313359, 32'd4264355552, 32'd2734768916, 32'd1309151649,
      32'd4149444226, 32'd3174756917, 32'd718787259,  32'd3951481745
   };

   localparam logic [4:0] ROT_AMOUNT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
   } md5_req_type;

   typedef struct packed {
      logic [31:0]           digest_word;
      logic [WORD_IDX_W-1:0] word_index;
      logic                  last_word;
   } md5_rsp_type;

   // Source of a byte entering the block buffer.
   typedef enum logic [1:0] {
      SRC_DATA,
      SRC_PAD,
      SRC_ZERO
   } md5_src_type;

   typedef struct packed {
      logic                  absorb_en;
      md5_src_type           src;
      logic                  save_len;
      logic                  len_lo;
      logic                  len_hi;
      logic                  comp_load;
      logic                  comp_round;
      logic                  comp_add;
      logic                  chain_init;
      logic [ROUND_W-1:0]    round;
      logic [ROUND_W-1:0]    rd_round;
      logic [WORD_IDX_W-1:0] emit_idx;
   } md5_cmd_type;

   typedef struct packed {
      logic [POS_W-1:0] pos;
   } md5_sts_type;

   // Index of the message word used in a given round.
   function automatic logic [WADDR_W-1:0] msg_index(input logic [ROUND_W-1:0] k);
      logic [3:0] k4;
      logic [3:0] g;
      k4 = k[3:0];
      case (k[5:4])
         2'd0:    g = k4;
         2'd1:    g = k4 + (k4 << 2) + 4'd1;
         2'd2:    g = k4 + (k4 << 1) + 4'd5;
         default: g = (k4 << 3) - k4;
      endcase
      return g;
   endfunction

   // Boolean function of one round.
   function automatic logic [31:0] round_fn(input logic [ROUND_W-1:0] k,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
      logic [31:0] f;
      case (k[5:4])
         2'd0:    f = (b & c) | (~b & d);
         2'd1:    f = (b & d) | (c & ~d);
         2'd2:    f = b ^ c ^ d;
         default: f = c ^ (b | ~d);
      endcase
      return f;
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] wide;
      wide = {x, x} << n;
      return wide[63:32];
   endfunction

endpackage

// ===== sv/md5_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module md5_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/md5_datapath.sv =====
`timescale 1ns / 1ps
// MD5 datapath: byte gathering, block buffer, length counter, round logic and chaining words.
// Depends on md5_pkg, md5_ram and assert_macros.svh.
`include "assert_macros.svh"

module md5_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  md5_pkg::md5_cmd_type cmd,
   input  logic [7:0]           data_byte,
   output md5_pkg::md5_sts_type sts,
   output md5_pkg::md5_rsp_type rsp
);

   logic [md5_pkg::BYTE_COUNT_W-1:0] cnt_ff, cnt_in;
   logic [md5_pkg::BYTE_COUNT_W-1:0] saved_ff, saved_in;
   logic [31:0]                      acc_ff, acc_in;
   logic [31:0]                      wk_ff [4];
   logic [31:0]                      wk_in [4];
   logic [31:0]                      ch_ff [4];
   logic [31:0]                      ch_in [4];

   logic [md5_pkg::POS_W-1:0]   pos;
   logic [7:0]                  new_byte;
   logic                        wr_en;
   logic [md5_pkg::WADDR_W-1:0] wr_addr;
   logic [31:0]                 wr_data;
   logic [md5_pkg::WADDR_W-1:0] rd_addr;
   logic [31:0]                 msg_word;
   logic [31:0]                 f_val;
   logic [31:0]                 sum;
   logic [31:0]                 new_b;
   logic [md5_pkg::BIT_COUNT_W-1:0] len_bits;

   assign pos = cnt_ff[md5_pkg::POS_W-1:0];
   assign sts.pos = pos;
   assign len_bits = {saved_ff, 3'b000};

   always_comb begin
      case (cmd.src)
         md5_pkg::SRC_DATA: new_byte = data_byte;
         md5_pkg::SRC_PAD:  new_byte = md5_pkg::PAD_BYTE;
         default:           new_byte = 8'h00;
      endcase
   end

   // Bytes shift in from the top so that the first byte of a word lands lowest.
   always_comb begin
      acc_in   = cmd.absorb_en ? {new_byte, acc_ff[31:8]} : acc_ff;
      saved_in = cmd.save_len ? cnt_ff : saved_ff;
      if (cmd.chain_init) begin
         cnt_in = '0;
      end else if (cmd.absorb_en) begin
         cnt_in = cnt_ff + 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_comb begin
      wr_en   = (cmd.absorb_en && (pos[1:0] == 2'd3)) || cmd.len_lo || cmd.len_hi;
      wr_addr = pos[md5_pkg::POS_W-1:2];
      wr_data = {new_byte, acc_ff[31:8]};
      if (cmd.len_lo) begin
         wr_addr = md5_pkg::LEN_LO_WORD;
         wr_data = len_bits[31:0];
      end else if (cmd.len_hi) begin
         wr_addr = md5_pkg::LEN_HI_WORD;
         wr_data = len_bits[63:32];
      end
   end

   assign rd_addr = md5_pkg::msg_index(cmd.rd_round);

   md5_ram #(
      .WIDTH(32),
      .DEPTH(md5_pkg::BLOCK_WORDS)
   ) u_block_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(msg_word)
   );

   always_comb begin
      f_val = md5_pkg::round_fn(cmd.round, wk_ff[1], wk_ff[2], wk_ff[3]);
      sum   = wk_ff[0] + f_val + md5_pkg::ROUND_CONST[cmd.round] + msg_word;
      new_b = wk_ff[1] + md5_pkg::rotl32(sum,
                 md5_pkg::ROT_AMOUNT[{cmd.round[5:4], cmd.round[1:0]}]);
   end

   always_comb begin
      wk_in = wk_ff;
      if (cmd.comp_load) begin
         wk_in = ch_ff;
      end else if (cmd.comp_round) begin
         wk_in[0] = wk_ff[3];
         wk_in[1] = new_b;
         wk_in[2] = wk_ff[1];
         wk_in[3] = wk_ff[2];
      end
   end

   always_comb begin
      ch_in = ch_ff;
      if (cmd.chain_init) begin
         ch_in = md5_pkg::CHAIN_INIT;
      end else if (cmd.comp_add) begin
         for (int i = 0; i < 4; i++) begin
            ch_in[i] = ch_ff[i] + wk_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ch_ff  <= md5_pkg::CHAIN_INIT;
      end else begin
         cnt_ff <= cnt_in;
         ch_ff  <= ch_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      saved_ff <= saved_in;
      wk_ff    <= wk_in;
   end

   assign rsp.digest_word = ch_ff[cmd.emit_idx];
   assign rsp.word_index  = cmd.emit_idx;
   assign rsp.last_word   = (cmd.emit_idx == md5_pkg::LAST_WORD);

   `MD5_ASSERT_NEXT(a_cnt_clear, clock, reset, cmd.chain_init, cnt_ff == '0)
   `MD5_ASSERT_NEXT(a_cnt_step, clock, reset, cmd.absorb_en && !cmd.chain_init, cnt_ff == $past(cnt_ff) + 1'b1)
   `MD5_ASSERT_IMPL(a_round_quiet, clock, reset, cmd.comp_round, !cmd.absorb_en && !wr_en)

endmodule

// ===== sv/md5_ctrl.sv =====
`timescale 1ns / 1ps
// MD5 controller: sequences absorbing, padding, length insertion, the 64 rounds and digest output.
// Depends on md5_pkg and assert_macros.svh.
`include "assert_macros.svh"

module md5_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  md5_pkg::md5_sts_type sts,
   output md5_pkg::md5_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAD,
      S_LEN_LO,
      S_LEN_HI,
      S_LOAD,
      S_ROUND,
      S_ADD,
      S_EMIT
   } state_type;

   state_type                         state_ff, state_in;
   state_type                         ret_ff, ret_in;
   logic [md5_pkg::ROUND_W-1:0]       round_ff, round_in;
   logic [md5_pkg::WORD_IDX_W-1:0]    word_ff, word_in;
   logic                              first_pad_ff, first_pad_in;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      round_in     = round_ff;
      word_in      = word_ff;
      first_pad_in = first_pad_ff;
      cmd          = '0;
      cmd.src      = md5_pkg::SRC_DATA;
      cmd.round    = round_ff;
      cmd.rd_round = round_ff + 1'b1;
      cmd.emit_idx = word_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_func == md5_pkg::FUNC_FINISH) begin
                  cmd.save_len = 1'b1;
                  first_pad_in = 1'b1;
                  state_in     = S_PAD;
               end else begin
                  cmd.absorb_en = 1'b1;
                  if (sts.pos == md5_pkg::LAST_POS) begin
                     ret_in   = S_IDLE;
                     state_in = S_LOAD;
                  end
               end
            end
         end
         S_PAD: begin
            cmd.absorb_en = 1'b1;
            cmd.src       = first_pad_ff ? md5_pkg::SRC_PAD : md5_pkg::SRC_ZERO;
            first_pad_in  = 1'b0;
            if (sts.pos == md5_pkg::LAST_POS) begin
               ret_in   = S_PAD;
               state_in = S_LOAD;
            end else if (sts.pos == md5_pkg::LAST_PAD_POS) begin
               state_in = S_LEN_LO;
            end
         end
         S_LEN_LO: begin
            cmd.len_lo = 1'b1;
            state_in   = S_LEN_HI;
         end
         S_LEN_HI: begin
            cmd.len_hi = 1'b1;
            ret_in     = S_EMIT;
            state_in   = S_LOAD;
         end
         S_LOAD: begin
            cmd.comp_load = 1'b1;
            cmd.rd_round  = '0;
            round_in      = '0;
            state_in      = S_ROUND;
         end
         S_ROUND: begin
            cmd.comp_round = 1'b1;
            round_in       = round_ff + 1'b1;
            if (round_ff == md5_pkg::LAST_ROUND) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            cmd.comp_add = 1'b1;
            word_in      = '0;
            state_in     = ret_ff;
         end
         S_EMIT: begin
            if (!rsp_stall) begin
               word_in = word_ff + 1'b1;
               if (word_ff == md5_pkg::LAST_WORD) begin
                  cmd.chain_init = 1'b1;
                  state_in       = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         round_ff     <= '0;
         word_ff      <= '0;
         first_pad_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         round_ff     <= round_in;
         word_ff      <= word_in;
         first_pad_ff <= first_pad_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_EMIT);

   `MD5_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, req_stall)
   `MD5_ASSERT_NEXT(a_rounds_end, clock, reset, (state_ff == S_ROUND) && (round_ff == md5_pkg::LAST_ROUND), state_ff == S_ADD)
   `MD5_ASSERT_NEXT(a_emit_done, clock, reset, rsp_valid && !rsp_stall && (word_ff == md5_pkg::LAST_WORD), !rsp_valid && !req_stall)

endmodule

// ===== sv/md5_message_digest.sv =====
`timescale 1ns / 1ps
// Top level of the MD5 message digest block: controller and datapath.
// Depends on md5_pkg, md5_ctrl and md5_datapath.

// MD5 over a byte stream. Each input transfer either absorbs one message byte
// (func = 0) or finishes the message (func = 1). An absorb transfer that
// completes a 64-byte block also runs the compression: a load of the working
// words, 64 rounds and an add into the chaining words. A finish transfer
// writes the 0x80 byte and zero bytes one per cycle up to byte 56 of a block
// (plus a compression if the padding spills into a new block), writes the
// 64-bit bit count as its low and then its high word, compresses once more
// and then offers the four digest words A to D as four result transfers, the
// least significant byte of each word being the first digest byte. After the
// last word is taken the chaining words and the byte count return to their
// initial values. The rate is set by the single round unit, which does one
// MD5 round per cycle reading one message word per cycle from a 16-word block
// buffer RAM. While any of this work is under way req_stall is high; no
// further input transfer is taken until all four result transfers have
// completed.
module md5_message_digest (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  md5_pkg::md5_req_type req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output md5_pkg::md5_rsp_type rsp_item
);

   md5_pkg::md5_cmd_type cmd;
   md5_pkg::md5_sts_type sts;

   // The controller sees only the function code; the data byte goes straight
   // to the datapath and is written in the same cycle as the transfer.
   md5_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func (req_item.func),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   // The result payload is read from the chaining registers, which hold still
   // while a result transfer is stalled.
   md5_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .data_byte(req_item.data_byte),
      .sts      (sts),
      .rsp      (rsp_item)
   );

endmodule
